// File: hdl/prex_pkg.sv
package prex_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int OP_WIDTH    = 2;
    localparam int DVD_WIDTH   = DATA_WIDTH + FRAC_BITS;
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int DIV_STEPS   = DVD_WIDTH;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int S_DATA_W    = ((DATA_WIDTH + OP_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int M_USER_W    = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_MUL,
        S_MUL_PACK,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_PACK,
        S_FOLD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic take;
        logic mul;
        logic mul_pack;
        logic div_init;
        logic div_step;
        logic div_pack;
        logic fold;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic pend_mul;
        logic pend_div;
        logic div_zero;
        logic div_done;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// File: hdl/prex_ctrl.sv
module prex_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  prex_pkg::sts_t sts,
    output prex_pkg::cmd_t cmd
);
    import prex_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (sts.pend_mul)
                        state_next = S_MUL;
                    else if (sts.pend_div)
                        state_next = S_DIV_INIT;
                    else
                        state_next = S_TAKE;
                end
            end
            S_TAKE:     state_next = S_FOLD;
            S_MUL:      state_next = S_MUL_PACK;
            S_MUL_PACK: state_next = S_FOLD;
            S_DIV_INIT: state_next = sts.div_zero ? S_FOLD : S_DIV_STEP;
            S_DIV_STEP: state_next = sts.div_done ? S_DIV_PACK : S_DIV_STEP;
            S_DIV_PACK: state_next = S_FOLD;
            S_FOLD:     state_next = sts.last ? S_EMIT : S_IDLE;
            S_EMIT:     state_next = sts.out_free ? S_IDLE : S_EMIT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_TAKE:     cmd.take     = 1'b1;
            S_MUL:      cmd.mul      = 1'b1;
            S_MUL_PACK: cmd.mul_pack = 1'b1;
            S_DIV_INIT: cmd.div_init = 1'b1;
            S_DIV_STEP: cmd.div_step = 1'b1;
            S_DIV_PACK: cmd.div_pack = 1'b1;
            S_FOLD:     cmd.fold     = 1'b1;
            S_EMIT:     cmd.emit     = sts.out_free;
            default:    cmd          = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hdl/prex_dp.sv
module prex_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [prex_pkg::DATA_WIDTH-1:0]   operand,
    input  logic [prex_pkg::OP_WIDTH-1:0]     next_op,
    input  logic                              last,
    input  prex_pkg::cmd_t                    cmd,
    output prex_pkg::sts_t                    sts,
    output logic [prex_pkg::DATA_WIDTH-1:0]   value,
    output logic                              div_by_zero,
    output logic                              saturated,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import prex_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MAX_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // {sat, value}: sign and magnitude to two's complement with clamping
    function automatic logic [DATA_WIDTH:0] sat_pack(input logic neg,
                                                     input logic [DVD_WIDTH-1:0] mag);
        logic [DVD_WIDTH-1:0]  lim;
        logic [DATA_WIDTH-1:0] m;
        logic                  sat;
        lim = neg ? DVD_WIDTH'(MAX_NEG) : DVD_WIDTH'(MAX_POS);
        sat = (mag > lim);
        m   = sat ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        return {sat, (neg ? (DATA_WIDTH'(0) - m) : m)};
    endfunction

    function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - v) : v;
    endfunction

    logic [DATA_WIDTH-1:0] x_reg,     x_next;
    op_t                   op_reg,    op_next;
    logic                  last_reg,  last_next;
    logic [DATA_WIDTH-1:0] a_mag_reg, a_mag_next;
    logic [DATA_WIDTH-1:0] b_mag_reg, b_mag_next;
    logic                  a_neg_reg, a_neg_next;
    logic                  q_neg_reg, q_neg_next;
    logic [PROD_WIDTH-1:0] prod_reg,  prod_next;
    logic [DATA_WIDTH:0]   rem_reg,   rem_next;
    logic [DVD_WIDTH-1:0]  dvd_reg,   dvd_next;
    logic [DVD_WIDTH-1:0]  quo_reg,   quo_next;
    logic [DIV_CNT_W-1:0]  cnt_reg,   cnt_next;

    logic [DATA_WIDTH-1:0] sum_reg,   sum_next;
    logic [DATA_WIDTH-1:0] term_reg,  term_next;
    logic                  tneg_reg,  tneg_next;
    op_t                   pend_reg,  pend_next;
    logic                  div0_reg,  div0_next;
    logic                  sat_reg,   sat_next;
    logic [DATA_WIDTH-1:0] out_value_reg, out_value_next;
    logic                  out_div0_reg,  out_div0_next;
    logic                  out_sat_reg,   out_sat_next;
    logic                  out_valid_reg, out_valid_next;

    logic [DATA_WIDTH:0]   r_shift;
    logic [DATA_WIDTH+1:0] r_diff;
    logic                  r_ge;
    logic [DATA_WIDTH:0]   mul_packed;
    logic [DATA_WIDTH:0]   div_packed;
    logic [DATA_WIDTH-1:0] addsub;
    logic                  addsub_ovf;
    logic                  ends_term;

    assign r_shift    = {rem_reg[DATA_WIDTH-1:0], dvd_reg[DVD_WIDTH-1]};
    assign r_diff     = {1'b0, r_shift} - {2'b00, b_mag_reg};
    assign r_ge       = !r_diff[DATA_WIDTH+1];
    assign mul_packed = sat_pack(q_neg_reg, prod_reg[FRAC_BITS +: DVD_WIDTH]);
    assign div_packed = sat_pack(q_neg_reg, quo_reg);
    assign addsub     = tneg_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
    assign addsub_ovf = tneg_reg
        ? ((sum_reg[DATA_WIDTH-1] != term_reg[DATA_WIDTH-1]) &&
           (addsub[DATA_WIDTH-1] != sum_reg[DATA_WIDTH-1]))
        : ((sum_reg[DATA_WIDTH-1] == term_reg[DATA_WIDTH-1]) &&
           (addsub[DATA_WIDTH-1] != sum_reg[DATA_WIDTH-1]));
    assign ends_term  = last_reg || (op_reg == OP_ADD) || (op_reg == OP_SUB);

    always_comb
    begin
        x_next     = x_reg;
        op_next    = op_reg;
        last_next  = last_reg;
        a_mag_next = a_mag_reg;
        b_mag_next = b_mag_reg;
        a_neg_next = a_neg_reg;
        q_neg_next = q_neg_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        term_next  = term_reg;
        tneg_next  = tneg_reg;
        pend_next  = pend_reg;
        div0_next  = div0_reg;
        sat_next   = sat_reg;
        out_value_next = out_value_reg;
        out_div0_next  = out_div0_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            x_next     = operand;
            op_next    = op_t'(next_op);
            last_next  = last;
            a_mag_next = mag_of(term_reg);
            b_mag_next = mag_of(operand);
            a_neg_next = term_reg[DATA_WIDTH-1];
            q_neg_next = term_reg[DATA_WIDTH-1] ^ operand[DATA_WIDTH-1];
        end

        if (cmd.take)
            term_next = x_reg;

        if (cmd.mul)
            prod_next = a_mag_reg * b_mag_reg;

        if (cmd.mul_pack)
        begin
            term_next = mul_packed[DATA_WIDTH-1:0];
            sat_next  = sat_reg | mul_packed[DATA_WIDTH];
        end

        if (cmd.div_init)
        begin
            rem_next = '0;
            dvd_next = {a_mag_reg, {FRAC_BITS{1'b0}}};
            quo_next = '0;
            cnt_next = '0;
            if (b_mag_reg == '0)
            begin
                div0_next = 1'b1;
                if (a_mag_reg == '0)
                    term_next = '0;
                else
                    term_next = a_neg_reg ? MAX_NEG : MAX_POS;
            end
        end

        if (cmd.div_step)
        begin
            rem_next = r_ge ? r_diff[DATA_WIDTH:0] : r_shift;
            dvd_next = {dvd_reg[DVD_WIDTH-2:0], 1'b0};
            quo_next = {quo_reg[DVD_WIDTH-2:0], r_ge};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.div_pack)
        begin
            term_next = div_packed[DATA_WIDTH-1:0];
            sat_next  = sat_reg | div_packed[DATA_WIDTH];
        end

        if (cmd.fold)
        begin
            if (ends_term)
            begin
                sum_next  = addsub_ovf ? (sum_reg[DATA_WIDTH-1] ? MAX_NEG : MAX_POS)
                                       : addsub;
                sat_next  = sat_reg | addsub_ovf;
                tneg_next = (op_reg == OP_SUB);
                pend_next = OP_ADD;
                term_next = '0;
            end
            else
            begin
                pend_next = op_reg;
            end
        end

        if (cmd.emit)
        begin
            out_value_next = sum_reg;
            out_div0_next  = div0_reg;
            out_sat_next   = sat_reg;
            out_valid_next = 1'b1;
            sum_next       = '0;
            term_next      = '0;
            tneg_next      = 1'b0;
            pend_next      = OP_ADD;
            div0_next      = 1'b0;
            sat_next       = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        op_reg        <= op_next;
        last_reg      <= last_next;
        a_mag_reg     <= a_mag_next;
        b_mag_reg     <= b_mag_next;
        a_neg_reg     <= a_neg_next;
        q_neg_reg     <= q_neg_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        out_value_reg <= out_value_next;
        out_div0_reg  <= out_div0_next;
        out_sat_reg   <= out_sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            term_reg      <= '0;
            tneg_reg      <= 1'b0;
            pend_reg      <= OP_ADD;
            div0_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            tneg_reg      <= tneg_next;
            pend_reg      <= pend_next;
            div0_reg      <= div0_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.pend_mul = (pend_reg == OP_MUL);
    assign sts.pend_div = (pend_reg == OP_DIV);
    assign sts.div_zero = (b_mag_reg == '0);
    assign sts.div_done = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign value       = out_value_reg;
    assign div_by_zero = out_div0_reg;
    assign saturated   = out_sat_reg;
    assign out_valid   = out_valid_reg;

endmodule

// File: hdl/precedence_expression_evaluator_top.sv
// channel   dir  handshake              payload
// s_axis    in   s_tvalid / s_tready    s_tdata: operand, next_op; s_tlast: last
// m_axis    out  m_tvalid / m_tready    m_tdata: value; m_tuser: div_by_zero, saturated
//
// one request at a time: add or subtract goes through S_TAKE and S_FOLD, a pending multiply
// through S_MUL, S_MUL_PACK and S_FOLD, a pending divide through S_DIV_INIT, 48 restoring
// divider steps, S_DIV_PACK and S_FOLD (a zero divisor skips to S_FOLD), then S_EMIT on last
// reset clears the running sum, the pending term, the pending operator and flags
// a finished result waits in the output register while the next request is taken;
// a new result stalls only while that register is still full
module precedence_expression_evaluator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prex_pkg::S_DATA_W-1:0]   s_tdata,   // operand, next_op, zero pad
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prex_pkg::M_DATA_W-1:0]   m_tdata,   // value
    output logic [prex_pkg::M_USER_W-1:0]   m_tuser    // div_by_zero, saturated
);
    import prex_pkg::*;

    cmd_t                  cmd;
    sts_t                  sts;
    logic [DATA_WIDTH-1:0] value;
    logic                  div_by_zero;
    logic                  saturated;

    prex_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    prex_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .operand     (s_tdata[DATA_WIDTH-1:0]),
        .next_op     (s_tdata[DATA_WIDTH +: OP_WIDTH]),
        .last        (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .value       (value),
        .div_by_zero (div_by_zero),
        .saturated   (saturated),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tdata = M_DATA_W'(value);
    assign m_tuser = {saturated, div_by_zero};

endmodule

// File: tb/precedence_expression_evaluator_top_test.sv
`timescale 1ns / 100ps

module precedence_expression_evaluator_top_test;

    import prex_pkg::*;

    localparam int NUM_RANDOM     = 1900;
    localparam int IDLE_PCT       = 19;
    localparam int QUIET_FROM     = 3000;
    localparam int QUIET_TO       = 7000;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 64;

    typedef logic [DATA_WIDTH-1:0] fx_t;

    typedef struct packed {
        fx_t  operand;
        op_t  next_op;
        logic last;
    } calc_req_t;

    typedef struct packed {
        fx_t  value;
        logic div0;
        logic sat;
    } calc_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;

    calc_req_t   pending_reqs[$];
    calc_res_t   expected_results[$];
    calc_req_t   in_flight;
    logic [S_DATA_W-1:0] req_word;

    // evaluator state mirror
    fx_t  acc_sum = '0;
    fx_t  term_val = '0;
    logic term_neg = 1'b0;
    op_t  pend_op = OP_ADD;
    logic flag_div0 = 1'b0;
    logic flag_sat = 1'b0;

    int   cyc = 0;
    int   stall_cycles = 0;
    int   error_count = 0;
    int   req_count = 0;

    precedence_expression_evaluator_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] magnitude_of(input fx_t v);
        fx_t m;
        m = v[DATA_WIDTH-1] ? -v : v;
        return 64'(m);
    endfunction

    // sign and magnitude back to a word, clamping to range
    function automatic fx_t clamp_pack(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        fx_t         m;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag > lim)
        begin
            flag_sat = 1'b1;
            mag = lim;
        end
        m = mag[DATA_WIDTH-1:0];
        return neg ? -m : m;
    endfunction

    function automatic fx_t fixed_mul(input fx_t a, input fx_t b);
        logic [63:0] prod;
        prod = magnitude_of(a) * magnitude_of(b);
        return clamp_pack(a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1], prod >> FRAC_BITS);
    endfunction

    function automatic fx_t fixed_div(input fx_t a, input fx_t b);
        logic [63:0] quot;
        if (magnitude_of(b) == 64'd0)
        begin
            flag_div0 = 1'b1;
            if (magnitude_of(a) == 64'd0)
                return '0;
            return a[DATA_WIDTH-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        quot = (magnitude_of(a) << FRAC_BITS) / magnitude_of(b);
        return clamp_pack(a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1], quot);
    endfunction

    function automatic fx_t fixed_addsub(input fx_t a, input fx_t b, input logic sub);
        fx_t  s;
        logic ovf;
        s = sub ? a - b : a + b;
        if (sub)
            ovf = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) && (s[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
        else
            ovf = (a[DATA_WIDTH-1] == b[DATA_WIDTH-1]) && (s[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
        if (ovf)
        begin
            flag_sat = 1'b1;
            s = a[DATA_WIDTH-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s;
    endfunction

    task automatic evaluate_request(input calc_req_t r);
        calc_res_t res;
        case (pend_op)
            OP_MUL:  term_val = fixed_mul(term_val, r.operand);
            OP_DIV:  term_val = fixed_div(term_val, r.operand);
            default: term_val = r.operand;
        endcase
        if (r.last || r.next_op == OP_ADD || r.next_op == OP_SUB)
        begin
            acc_sum  = fixed_addsub(acc_sum, term_val, term_neg);
            term_neg = (r.next_op == OP_SUB);
            pend_op  = OP_ADD;
            term_val = '0;
        end
        else
        begin
            pend_op = r.next_op;
        end
        if (r.last)
        begin
            res.value = acc_sum;
            res.div0  = flag_div0;
            res.sat   = flag_sat;
            expected_results = {expected_results, res};
            acc_sum   = '0;
            term_val  = '0;
            term_neg  = 1'b0;
            pend_op   = OP_ADD;
            flag_div0 = 1'b0;
            flag_sat  = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_request(input logic [31:0] operand, input op_t op, input logic last);
        calc_req_t r;
        r.operand = operand;
        r.next_op = op;
        r.last    = last;
        pending_reqs = {pending_reqs, r};
        req_count++;
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2:
            begin
                v = 32'($urandom_range(8)) << FRAC_BITS;
                if ($urandom_range(3) == 0)
                    v = v | 32'($urandom_range(16'hFFFF));
            end
            3:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            4, 5:    v = $urandom;
            6:       v = 32'($urandom_range(32'h1_FFFF));
            default: v = 32'($urandom_range(32'h3F_FFFF));
        endcase
        if ($urandom_range(1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic op_t random_op();
        return op_t'($urandom_range(3));
    endfunction

    // driver
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                evaluate_request(in_flight);
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() > 0 &&
                    ((cyc >= QUIET_FROM && cyc < QUIET_TO) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    in_flight = pending_reqs.pop_front();
                    req_word = '0;
                    req_word[DATA_WIDTH-1:0] = in_flight.operand;
                    req_word[DATA_WIDTH+OP_WIDTH-1:DATA_WIDTH] = in_flight.next_op;
                    s_tdata  <= req_word;
                    s_tlast  <= in_flight.last;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result, value", m_tdata[DATA_WIDTH-1:0], 'x);
                end
                else
                begin
                    calc_res_t want;
                    want = expected_results.pop_front();
                    if (m_tdata[DATA_WIDTH-1:0] !== want.value)
                        report_mismatch("value", m_tdata[DATA_WIDTH-1:0], want.value);
                    if (m_tuser[0] !== want.div0)
                        report_mismatch("div_by_zero", 32'(m_tuser[0]), 32'(want.div0));
                    if (m_tuser[1] !== want.sat)
                        report_mismatch("saturated", 32'(m_tuser[1]), 32'(want.sat));
                end
            end
            m_tready <= (cyc >= QUIET_FROM && cyc < QUIET_TO) ||
                        ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int len;
        int target;

        // saturating add and subtract, next_op ignored on last
        add_request(32'h7FFF_FFFF, OP_ADD, 1'b0);
        add_request(32'h7FFF_FFFF, OP_DIV, 1'b1);
        add_request(32'h8000_0000, OP_SUB, 1'b0);
        add_request(32'h0000_0001, OP_MUL, 1'b1);
        // product overflow
        add_request(32'h7FFF_FFFF, OP_MUL, 1'b0);
        add_request(32'h7FFF_FFFF, OP_ADD, 1'b1);
        // divide by zero: zero, positive and negative dividends
        add_request(32'h0000_0000, OP_DIV, 1'b0);
        add_request(32'h0000_0000, OP_SUB, 1'b1);
        add_request(32'h0005_0000, OP_DIV, 1'b0);
        add_request(32'h0000_0000, OP_ADD, 1'b1);
        add_request(32'hFFFD_0000, OP_DIV, 1'b0);
        add_request(32'h0000_0000, OP_ADD, 1'b1);
        // truncation toward zero on negative products and quotients
        add_request(32'hFFFE_8000, OP_MUL, 1'b0);
        add_request(32'h0000_0003, OP_DIV, 1'b0);
        add_request(32'h0003_0000, OP_ADD, 1'b1);
        // 2 + 3 * 4 - 6 / 2
        add_request(32'h0002_0000, OP_ADD, 1'b0);
        add_request(32'h0003_0000, OP_MUL, 1'b0);
        add_request(32'h0004_0000, OP_SUB, 1'b0);
        add_request(32'h0006_0000, OP_DIV, 1'b0);
        add_request(32'h0002_0000, OP_ADD, 1'b1);
        // quotient overflow
        add_request(32'h7FFF_FFFF, OP_DIV, 1'b0);
        add_request(32'h0000_0001, OP_ADD, 1'b1);
        // single operand expression, then a product of two negative operands
        add_request(32'h8000_0000, OP_SUB, 1'b1);
        add_request(32'hFFFF_FFFF, OP_MUL, 1'b0);
        add_request(32'hFFFF_FFFF, OP_ADD, 1'b1);

        target = req_count + NUM_RANDOM;
        while (req_count < target)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(6, 1);
            for (int k = 1; k < len; k++)
                add_request(random_operand(), random_op(), 1'b0);
            add_request(random_operand(), random_op(), 1'b1);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/prex_pkg.sv
hdl/prex_ctrl.sv
hdl/prex_dp.sv
hdl/precedence_expression_evaluator_top.sv
tb/precedence_expression_evaluator_top_test.sv
